@@ rtl/tlms_pkg.sv @@
// ----------------------------------------------------------------------------
// tlms_pkg
// Shared types, constants and pattern tables of the tilt LED matrix scanner.
// ----------------------------------------------------------------------------
package tlms_pkg;

	localparam int DEF_MATRIX_SIZE   = 8;
	localparam int DEF_PATTERN_COUNT = 7;

	localparam int TILT_W      = 12;
	localparam int CFG_W       = 9;
	localparam int SLOT_W      = 3;
	localparam int IDX_W       = 3;
	localparam int BYTE_W      = 8;
	localparam int COUNT_W     = 8;
	localparam int POS_W       = 18;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic {
		CFG_SMOOTHING_WEIGHT = 1'b0,
		CFG_SAMPLE_PERIOD    = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		TGT_COL = 1'b0,
		TGT_ROW = 1'b1
	} target_t;

	localparam logic [CFG_W-1:0] WEIGHT_RESET = 9'd205;
	localparam logic [CFG_W-1:0] WEIGHT_MAX   = 9'd256;
	localparam logic [CFG_W-1:0] PERIOD_RESET = 9'd16;
	localparam logic [CFG_W-1:0] PERIOD_MIN   = 9'd1;
	localparam logic [CFG_W-1:0] PERIOD_MAX   = 9'd256;

	localparam logic [IDX_W-1:0] PATTERN_RESET = 3'd1;

	localparam logic signed [POS_W-1:0] POS_RESET = 18'sd12288;
	localparam logic signed [POS_W-1:0] POS_MAX   = 18'sd131071;
	localparam logic signed [POS_W-1:0] POS_MIN   = {1'b1, {(POS_W-1){1'b0}}};

	typedef logic [BYTE_W-1:0] byte_t;

	localparam byte_t COL_ROM [8][8] = '{
		'{8'd1,   8'd2,   8'd4,   8'd8,   8'd16,  8'd32,  8'd64,  8'd128},
		'{8'd3,   8'd7,   8'd14,  8'd28,  8'd56,  8'd112, 8'd224, 8'd192},
		'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
		'{8'd1,   8'd2,   8'd4,   8'd8,   8'd16,  8'd32,  8'd64,  8'd128},
		'{8'd254, 8'd253, 8'd251, 8'd247, 8'd239, 8'd223, 8'd191, 8'd127},
		'{8'd252, 8'd248, 8'd241, 8'd227, 8'd199, 8'd143, 8'd31,  8'd127},
		'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
		'{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0}
	};

	localparam byte_t ROW_ROM [8][8] = '{
		'{8'd1,   8'd2,   8'd4,   8'd8,   8'd16,  8'd32,  8'd64,  8'd128},
		'{8'd3,   8'd7,   8'd14,  8'd28,  8'd56,  8'd112, 8'd224, 8'd192},
		'{8'd1,   8'd2,   8'd4,   8'd8,   8'd16,  8'd32,  8'd64,  8'd128},
		'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
		'{8'd254, 8'd253, 8'd251, 8'd247, 8'd239, 8'd223, 8'd191, 8'd127},
		'{8'd252, 8'd248, 8'd241, 8'd227, 8'd199, 8'd143, 8'd31,  8'd127},
		'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
		'{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0}
	};

	// One classified frame as handed from the front end to the back end.
	typedef struct packed {
		logic                     sample;
		logic [IDX_W-1:0]         idx;
		logic signed [TILT_W-1:0] tilt_x;
		logic signed [TILT_W-1:0] tilt_y;
	} job_t;

endpackage

@@ rtl/tlms_ifs.sv @@
// ----------------------------------------------------------------------------
// tlms_ifs
// Valid/ready channel interfaces for frames in and driver bytes out.
// ----------------------------------------------------------------------------
interface tlms_frame_if import tlms_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     button_pressed;
	logic signed [TILT_W-1:0] tilt_x;
	logic signed [TILT_W-1:0] tilt_y;

	modport source (output valid, button_pressed, tilt_x, tilt_y, input ready);
	modport sink   (input valid, button_pressed, tilt_x, tilt_y, output ready);
endinterface

interface tlms_result_if import tlms_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              target;
	logic [BYTE_W-1:0] drive_byte;
	logic              last;

	modport source (output valid, target, drive_byte, last, input ready);
	modport sink   (input valid, target, drive_byte, last, output ready);
endinterface

@@ rtl/tilt_led_matrix_scanner.sv @@
// ----------------------------------------------------------------------------
// tilt_led_matrix_scanner
// Tilt-steered LED matrix scanner: frames in, driver bytes out.
// ----------------------------------------------------------------------------
// A sample frame passes four arithmetic steps (divide, filter, sum, column
// lookup) before its column byte; row bytes follow one per cycle through the
// single result register while the receiver is ready, for every frame. The
// next frame is taken as the last row byte loads. Reset puts the config,
// control, counter and position state to initial values at once, not the data.
module tilt_led_matrix_scanner import tlms_pkg::*; #(
	parameter int MATRIX_SIZE   = DEF_MATRIX_SIZE,
	parameter int PATTERN_COUNT = DEF_PATTERN_COUNT
) (
	input  logic             clk,
	input  logic             arst_n,
	tlms_frame_if.sink       frame,
	tlms_result_if.source    result,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0] weight_q;
	logic [CFG_W-1:0] period_q;
	logic             push;
	job_t             push_job;
	logic             full;
	logic             pop;
	job_t             pop_job;
	logic             empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_RESET;
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_SMOOTHING_WEIGHT: begin
					weight_q <= (cfg_data > WEIGHT_MAX) ? WEIGHT_MAX : cfg_data;
				end
				CFG_SAMPLE_PERIOD: begin
					if (cfg_data == '0) begin
						period_q <= PERIOD_MIN;
					end else if (cfg_data > PERIOD_MAX) begin
						period_q <= PERIOD_MAX;
					end else begin
						period_q <= cfg_data;
					end
				end
			endcase
		end
	end

	tlms_front #(
		.PATTERN_COUNT (PATTERN_COUNT)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.frame         (frame),
		.sample_period (period_q),
		.full          (full),
		.push          (push),
		.push_job      (push_job)
	);

	tlms_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (empty)
	);

	tlms_back #(
		.MATRIX_SIZE (MATRIX_SIZE)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.smoothing_weight (weight_q),
		.empty            (empty),
		.job              (pop_job),
		.pop              (pop),
		.result           (result)
	);

endmodule

@@ rtl/tlms_front.sv @@
// ----------------------------------------------------------------------------
// tlms_front
// Accepts frames, advances the pattern index and marks sample frames.
// ----------------------------------------------------------------------------
module tlms_front import tlms_pkg::*; #(
	parameter int PATTERN_COUNT = DEF_PATTERN_COUNT
) (
	input  logic             clk,
	input  logic             arst_n,
	tlms_frame_if.sink       frame,
	input  logic [CFG_W-1:0] sample_period,
	input  logic             full,
	output logic             push,
	output job_t             push_job
);

	logic [IDX_W-1:0]   pattern_q;
	logic [COUNT_W-1:0] frame_cnt_q;
	logic [IDX_W-1:0]   pattern_next;
	logic               pattern_wrap;
	logic               frame_wrap;

	assign frame.ready = !full;
	assign push        = frame.valid && frame.ready;

	assign pattern_wrap = ({1'b0, pattern_q} + 4'd1) >= (IDX_W+1)'(PATTERN_COUNT);
	assign frame_wrap   = ({1'b0, frame_cnt_q} + 9'd1) >= sample_period;

	always_comb begin
		pattern_next = pattern_q;
		if (frame.button_pressed) begin
			pattern_next = pattern_wrap ? '0 : pattern_q + 3'd1;
		end
	end

	assign push_job.sample = (frame_cnt_q == '0);
	assign push_job.idx    = pattern_next;
	assign push_job.tilt_x = frame.tilt_x;
	assign push_job.tilt_y = frame.tilt_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q   <= PATTERN_RESET;
			frame_cnt_q <= '0;
		end else if (push) begin
			pattern_q   <= pattern_next;
			frame_cnt_q <= frame_wrap ? '0 : frame_cnt_q + 8'd1;
		end
	end

endmodule

@@ rtl/tlms_queue.sv @@
// ----------------------------------------------------------------------------
// tlms_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tlms_queue import tlms_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t pop_job,
	output logic empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = entry_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/tlms_back.sv @@
// ----------------------------------------------------------------------------
// tlms_back
// Runs the tilt arithmetic on sample frames and emits the driver bytes.
// ----------------------------------------------------------------------------
module tlms_back import tlms_pkg::*; #(
	parameter int MATRIX_SIZE = DEF_MATRIX_SIZE
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CFG_W-1:0] smoothing_weight,
	input  logic             empty,
	input  job_t             job,
	output logic             pop,
	tlms_result_if.source    result
);

	localparam int DIV_N_W   = 24;
	localparam int RECIP_W   = 25;
	localparam int DIV_SHIFT = 33;
	localparam int QUOT_W    = 16;
	localparam int PROD_W    = 28;
	localparam int SUM_W     = PROD_W + 1;
	localparam int SHR       = 8;
	localparam int SH_W      = SUM_W - SHR;

	// Reciprocal of 362 scaled by 2^33, rounded up; exact for every numerator here.
	localparam logic [RECIP_W-1:0]        RECIP       = 25'd23729102;
	localparam logic [DIV_N_W-1:0]        DIV_BIAS    = 24'd181;
	localparam logic [TILT_W:0]           TILT_OFFSET = 13'd1440;
	localparam logic signed [POS_W-1:0]   POS_BASE    = 18'sd28672;
	localparam logic signed [SUM_W-1:0]   ROUND_HALF  = 29'sd128;
	localparam logic [POS_W-1:0]          SLOT_HALF   = 18'd2048;
	localparam int                        SLOT_SHIFT  = 12;
	localparam logic [SLOT_W-1:0]         SLOT_MAX    = SLOT_W'(MATRIX_SIZE - 1);
	localparam logic [SLOT_W:0]           SIZE_EXT    = (SLOT_W+1)'(MATRIX_SIZE);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_FILT,
		ST_SUM,
		ST_COL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic               neg;
		logic [DIV_N_W-1:0] num;
	} lane_pre_t;

	state_t                   state_q;
	logic                     neg_q    [2];
	logic [DIV_N_W-1:0]       num_q    [2];
	logic [QUOT_W-1:0]        quot_q   [2];
	logic signed [PROD_W-1:0] prod_t_q [2];
	logic signed [PROD_W-1:0] prod_p_q [2];
	logic signed [POS_W-1:0]  pos_q    [2];
	logic [IDX_W-1:0]         idx_q;
	byte_t                    row_pattern_q;
	logic [SLOT_W-1:0]        scan_q;
	logic [SLOT_W-1:0]        k_q;

	logic                     out_valid_q;
	logic                     out_target_q;
	byte_t                    out_byte_q;
	logic                     out_last_q;

	logic                     load;
	logic                     take;
	lane_pre_t                pre      [2];
	logic [QUOT_W-1:0]        quot     [2];
	logic signed [POS_W-1:0]  tgt      [2];
	logic signed [POS_W-1:0]  filt     [2];
	logic [CFG_W-1:0]         inv_weight;
	logic [SLOT_W-1:0]        row_slot;
	logic [SLOT_W-1:0]        col_slot;
	logic [SLOT_W:0]          scan_sum;
	logic [SLOT_W-1:0]        scan_row;
	logic                     k_last;

	assign result.valid      = out_valid_q;
	assign result.target     = out_target_q;
	assign result.drive_byte = out_byte_q;
	assign result.last       = out_last_q;

	// The result register takes a new byte when it is empty or being drained.
	assign load   = !out_valid_q || result.ready;
	assign k_last = (k_q == SLOT_MAX);
	assign take   = !empty && ((state_q == ST_IDLE) ||
	                           ((state_q == ST_EMIT) && load && k_last));
	assign pop    = take;

	function automatic lane_pre_t lane_prep(logic signed [TILT_W-1:0] a);
		logic [TILT_W:0]   off;
		logic [TILT_W-1:0] mag;
		lane_pre_t         r;
		off   = {a[TILT_W-1], a} + TILT_OFFSET;
		mag   = off[TILT_W] ? TILT_W'(-off) : off[TILT_W-1:0];
		r.neg = off[TILT_W];
		r.num = {mag, 12'b0} + DIV_BIAS;
		return r;
	endfunction

	function automatic logic [SLOT_W-1:0] slot_of(logic signed [POS_W-1:0] p);
		logic [POS_W-1:0] biased;
		logic [POS_W-SLOT_SHIFT-1:0] s;
		biased = {1'b0, p[POS_W-2:0]} + SLOT_HALF;
		s      = biased[POS_W-1:SLOT_SHIFT];
		if (p[POS_W-1]) begin
			return '0;
		end else if (s > (POS_W-SLOT_SHIFT)'(SLOT_MAX)) begin
			return SLOT_MAX;
		end else begin
			return s[SLOT_W-1:0];
		end
	endfunction

	assign pre[0]     = lane_prep(job.tilt_x);
	assign pre[1]     = lane_prep(job.tilt_y);
	assign inv_weight = WEIGHT_MAX - smoothing_weight;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			logic [DIV_N_W+RECIP_W-1:0] prod;
			logic signed [POS_W-1:0]    qs;
			logic signed [SUM_W-1:0]    s;
			logic signed [SH_W-1:0]     sh;
			prod    = (DIV_N_W+RECIP_W)'(num_q[i]) * (DIV_N_W+RECIP_W)'(RECIP);
			quot[i] = prod[DIV_SHIFT +: QUOT_W];
			qs      = {2'b00, quot_q[i]};
			tgt[i]  = neg_q[i] ? POS_BASE + qs : POS_BASE - qs;
			s       = {prod_t_q[i][PROD_W-1], prod_t_q[i]} +
			          {prod_p_q[i][PROD_W-1], prod_p_q[i]} + ROUND_HALF;
			sh      = s[SUM_W-1:SHR];
			if (sh > SH_W'(POS_MAX)) begin
				filt[i] = POS_MAX;
			end else if (sh < SH_W'(POS_MIN)) begin
				filt[i] = POS_MIN;
			end else begin
				filt[i] = sh[POS_W-1:0];
			end
		end
	end

	// Lane 0 steers the column byte, lane 1 the row pattern.
	assign row_slot = slot_of(pos_q[0]);
	assign col_slot = slot_of(pos_q[1]);

	assign scan_sum = {1'b0, scan_q} + {1'b0, k_q};
	assign scan_row = (scan_sum >= SIZE_EXT) ? SLOT_W'(scan_sum - SIZE_EXT)
	                                         : scan_sum[SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			pos_q[0]      <= POS_RESET;
			pos_q[1]      <= POS_RESET;
			row_pattern_q <= '0;
			scan_q        <= '0;
			k_q           <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
				end
				ST_DIV: begin
					quot_q[0] <= quot[0];
					quot_q[1] <= quot[1];
					state_q   <= ST_FILT;
				end
				ST_FILT: begin
					for (int i = 0; i < 2; i++) begin
						prod_t_q[i] <= PROD_W'($signed({1'b0, inv_weight})) *
						               PROD_W'(tgt[i]);
						prod_p_q[i] <= PROD_W'($signed({1'b0, smoothing_weight})) *
						               PROD_W'(pos_q[i]);
					end
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					pos_q[0] <= filt[0];
					pos_q[1] <= filt[1];
					state_q  <= ST_COL;
				end
				ST_COL: begin
					if (load) begin
						out_valid_q   <= 1'b1;
						out_target_q  <= TGT_COL;
						out_byte_q    <= COL_ROM[idx_q][row_slot];
						out_last_q    <= 1'b0;
						row_pattern_q <= ROW_ROM[idx_q][col_slot];
						k_q           <= '0;
						state_q       <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load) begin
						out_valid_q  <= 1'b1;
						out_target_q <= TGT_ROW;
						out_byte_q   <= row_pattern_q & (byte_t'(1) << scan_row);
						out_last_q   <= k_last;
						if (k_last) begin
							scan_q  <= (scan_q == SLOT_MAX) ? '0 : scan_q + SLOT_W'(1);
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q + SLOT_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (take) begin
				idx_q <= job.idx;
				k_q   <= '0;
				if (job.sample) begin
					neg_q[0] <= pre[0].neg;
					neg_q[1] <= pre[1].neg;
					num_q[0] <= pre[0].num;
					num_q[1] <= pre[1].num;
					state_q  <= ST_DIV;
				end else begin
					state_q <= ST_EMIT;
				end
			end
		end
	end

	a_last_is_row: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.last |-> result.target == TGT_ROW)
		else $error("last flag on a column byte");

	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> (k_q <= SLOT_MAX) && (scan_q <= SLOT_MAX))
		else $error("row index beyond matrix size");

	a_sample_start: assert property (@(posedge clk) disable iff (!arst_n)
		take && job.sample |=> state_q == ST_DIV)
		else $error("sample frame did not start the arithmetic sequence");

	a_col_then_rows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COL && load |=> state_q == ST_EMIT && k_q == '0)
		else $error("column byte not followed by row scan");

endmodule
